[rtl/assert_macros.svh]
// Assertion macros for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold prop on every rising clock edge outside reset.
`define AAVR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("aavr property failed");

// Flag expr whenever it is seen true outside reset.
`define AAVR_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("aavr forbidden condition seen");

`endif

[rtl/aavr_pkg.sv]
// Package for the axis-angle vector rotator: stage map, trig constants, arctangent table.
`timescale 1ns / 1ps
`default_nettype none
package aavr_pkg;

   localparam int ANGLE_WIDTH  = 26;
   localparam int ATAN_ENTRIES = 24;
   localparam int SQRT_STAGES  = 32;
   localparam int DIV_STAGES   = 31;

   localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
   localparam logic [26:0] DEG_TO_RAD  = 27'd74961321;

   localparam int S_MAG     = 1;
   localparam int S_MAX     = 2;
   localparam int S_NB      = 3;
   localparam int S_NORM    = 4;
   localparam int S_SQ      = 5;
   localparam int S_SUM     = 6;
   localparam int S_ROOT    = S_SUM + SQRT_STAGES;
   localparam int S_QUOT    = S_ROOT + DIV_STAGES;
   localparam int S_UNIT    = S_QUOT + 1;
   localparam int S_M1      = S_UNIT + 1;
   localparam int S_M2      = S_UNIT + 2;
   localparam int S_M3      = S_UNIT + 3;
   localparam int S_M4      = S_UNIT + 4;
   localparam int LATENCY   = S_UNIT + 5;

   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] a;
      case (idx)
         5'd0:    a = 32'h3243F6A8;
         5'd1:    a = 32'h1DAC6705;
         5'd2:    a = 32'h0FADBAFC;
         5'd3:    a = 32'h07F56EA6;
         5'd4:    a = 32'h03FEAB76;
         5'd5:    a = 32'h01FFD55B;
         5'd6:    a = 32'h00FFFAAA;
         5'd7:    a = 32'h007FFF55;
         5'd8:    a = 32'h003FFFEA;
         5'd9:    a = 32'h001FFFFD;
         5'd10:   a = 32'h000FFFFF;
         5'd11:   a = 32'h0007FFFF;
         5'd12:   a = 32'h0003FFFF;
         5'd13:   a = 32'h0001FFFF;
         5'd14:   a = 32'h0000FFFF;
         5'd15:   a = 32'h00007FFF;
         5'd16:   a = 32'h00003FFF;
         5'd17:   a = 32'h00001FFF;
         5'd18:   a = 32'h00000FFF;
         5'd19:   a = 32'h000007FF;
         5'd20:   a = 32'h000003FF;
         5'd21:   a = 32'h000001FF;
         5'd22:   a = 32'h000000FF;
         5'd23:   a = 32'h0000007F;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

[rtl/axis_angle_vector_rotate.sv]
// Top level of the axis-angle vector rotator (Rodrigues formula), fully pipelined.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Input channel: drive req_vec_*, req_axis_* and req_angle_deg (all Q.FRAC_BITS)
//   with start high; a beat is taken at each rising edge where start is high and
//   busy is low. busy stays low, so a new beat may enter on every clock.
//   Result channel: rsp_strobe is high for one cycle with rsp_rot_*, rsp_axis_zero
//   and rsp_saturated; the beat is taken at the edge that ends that cycle.
//   Throughput: one beat per cycle. The 32-step square root of the axis length and
//   the 31-step divider that scales the axis are pipelined one step per stage.
//   The angle is folded to +-90 degrees and fed to a pipelined CORDIC rotator that
//   runs alongside the axis path.
//   A zero-length axis passes the vector through with rsp_axis_zero set.
//   Components are clipped to COMP_WIDTH signed bits; rsp_saturated marks clipping.
//   Reset clears every valid bit in the pipeline; no result appears until new beats
//   enter. The receiver cannot stall, so the pipeline never holds.
module axis_angle_vector_rotate import aavr_pkg::*; #(
   parameter int COMP_WIDTH      = 32,
   parameter int FRAC_BITS       = 16,
   parameter int TRIG_ITERATIONS = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire  signed [COMP_WIDTH-1:0]     req_vec_x,
   input  wire  signed [COMP_WIDTH-1:0]     req_vec_y,
   input  wire  signed [COMP_WIDTH-1:0]     req_vec_z,
   input  wire  signed [COMP_WIDTH-1:0]     req_axis_x,
   input  wire  signed [COMP_WIDTH-1:0]     req_axis_y,
   input  wire  signed [COMP_WIDTH-1:0]     req_axis_z,
   input  wire  signed [ANGLE_WIDTH-1:0]    req_angle_deg,
   output logic                             rsp_strobe,
   output logic signed [COMP_WIDTH-1:0]     rsp_rot_x,
   output logic signed [COMP_WIDTH-1:0]     rsp_rot_y,
   output logic signed [COMP_WIDTH-1:0]     rsp_rot_z,
   output logic                             rsp_axis_zero,
   output logic                             rsp_saturated
);

   localparam int CW  = COMP_WIDTH;
   localparam int NBW = $clog2(CW + 1);
   localparam int WP  = CW + 8;
   localparam int AW  = 34;
   localparam int PW  = WP + AW;
   localparam int NIT = (TRIG_ITERATIONS < ATAN_ENTRIES) ? TRIG_ITERATIONS : ATAN_ENTRIES;

   localparam longint FULL_L  = longint'(360) << FRAC_BITS;
   localparam longint ANG_MAX = longint'(1) << (ANGLE_WIDTH - 1);
   localparam int     QB_RAW  = $clog2(ANG_MAX / FULL_L + 1);
   localparam int     QB      = (QB_RAW < 1) ? 1 : QB_RAW;
   localparam int     T_END   = QB + 6 + NIT;
   localparam int     DLY     = S_UNIT - T_END;

   localparam logic signed [AW-1:0] FULL    = AW'(FULL_L);
   localparam logic signed [AW-1:0] HALF    = AW'(longint'(180) << FRAC_BITS);
   localparam logic signed [AW-1:0] QUARTER = AW'(longint'(90) << FRAC_BITS);
   localparam logic signed [AW-1:0] Q30_ONE = AW'(longint'(1) << 30);
   localparam logic [63:0]          RND     = 64'd1 << (FRAC_BITS + 1);

   localparam logic signed [WP-1:0] SAT_HI = WP'((longint'(1) << (CW - 1)) - 1);
   localparam logic signed [WP-1:0] SAT_LO = -SAT_HI - WP'(1);

   typedef struct packed {
      logic [2:0][CW-1:0] v;
      logic [2:0]         neg;
      logic               zero;
   } carry_type;

   typedef struct packed {
      logic [63:0]        n;
      logic [63:0]        res;
      logic [2:0][29:0]   nm;
   } root_type;

   typedef struct packed {
      logic [31:0]        len;
      logic [2:0][32:0]   rem;
      logic [2:0][30:0]   q;
      logic [2:0][29:0]   nm;
   } quot_type;

   typedef struct packed {
      logic [AW-1:0]      rem;
      logic               neg;
   } mod_type;

   typedef struct packed {
      logic signed [AW-1:0] x;
      logic signed [AW-1:0] y;
      logic signed [AW-1:0] z;
      logic                 flip;
   } cordic_type;

   function automatic logic signed [WP-1:0] mulq(input logic signed [WP-1:0] a,
                                                 input logic signed [AW-1:0] b);
      logic signed [PW-1:0] p;
      p = PW'(a) * PW'(b);
      return p[WP+29:30];
   endfunction

   logic        vld_ff [1:LATENCY];
   carry_type   car_ff [1:LATENCY-1];
   logic        accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= LATENCY; k++) vld_ff[k] <= 1'b0;
      end else begin
         vld_ff[1] <= accept;
         for (int k = 2; k <= LATENCY; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      car_ff[1].v    <= {req_vec_z, req_vec_y, req_vec_x};
      car_ff[1].neg  <= {req_axis_z[CW-1], req_axis_y[CW-1], req_axis_x[CW-1]};
      car_ff[1].zero <= (req_axis_x == '0) && (req_axis_y == '0) && (req_axis_z == '0);
      for (int k = 2; k < LATENCY; k++) car_ff[k] <= car_ff[k-1];
   end

   // axis length front end
   logic [2:0][CW-1:0] mag_ff, mag2_ff, mag3_ff;
   logic [CW-1:0]      max_ff;
   logic [NBW-1:0]     nb_ff, nb_in;
   logic [2:0][29:0]   nm_ff, nm5_ff;
   logic [2:0][59:0]   sq_ff;

   always_comb begin
      nb_in = '0;
      for (int b = 0; b < CW; b++) begin
         if (max_ff[b]) nb_in = NBW'(b + 1);
      end
   end

   always_ff @(posedge clock) begin
      logic [CW+29:0] wide;
      mag_ff[0] <= req_axis_x[CW-1] ? CW'(-req_axis_x) : CW'(req_axis_x);
      mag_ff[1] <= req_axis_y[CW-1] ? CW'(-req_axis_y) : CW'(req_axis_y);
      mag_ff[2] <= req_axis_z[CW-1] ? CW'(-req_axis_z) : CW'(req_axis_z);
      mag2_ff   <= mag_ff;
      if (mag_ff[0] >= mag_ff[1] && mag_ff[0] >= mag_ff[2]) begin
         max_ff <= mag_ff[0];
      end else if (mag_ff[1] >= mag_ff[2]) begin
         max_ff <= mag_ff[1];
      end else begin
         max_ff <= mag_ff[2];
      end
      mag3_ff <= mag2_ff;
      nb_ff   <= nb_in;
      for (int i = 0; i < 3; i++) begin
         wide      = {mag3_ff[i], 30'b0} >> nb_ff;
         nm_ff[i]  <= wide[29:0];
         sq_ff[i]  <= 60'(nm_ff[i]) * 60'(nm_ff[i]);
      end
      nm5_ff <= nm_ff;
   end

   // square root, one result bit per stage
   root_type rt_ff [0:SQRT_STAGES];

   always_ff @(posedge clock) begin
      rt_ff[0].n   <= 64'(sq_ff[0]) + 64'(sq_ff[1]) + 64'(sq_ff[2]);
      rt_ff[0].res <= '0;
      rt_ff[0].nm  <= nm5_ff;
   end

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_root
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      always_ff @(posedge clock) begin
         logic [63:0] trial;
         trial = rt_ff[k].res + BIT;
         rt_ff[k+1].nm <= rt_ff[k].nm;
         if (rt_ff[k].n >= trial) begin
            rt_ff[k+1].n   <= rt_ff[k].n - trial;
            rt_ff[k+1].res <= (rt_ff[k].res >> 1) + BIT;
         end else begin
            rt_ff[k+1].n   <= rt_ff[k].n;
            rt_ff[k+1].res <= rt_ff[k].res >> 1;
         end
      end
   end

   // axis scaling, one quotient bit per stage
   quot_type qt_src [0:DIV_STAGES-1];
   quot_type qt_ff  [1:DIV_STAGES];

   always_comb begin
      qt_src[0].len = rt_ff[SQRT_STAGES].res[31:0];
      qt_src[0].nm  = rt_ff[SQRT_STAGES].nm;
      qt_src[0].q   = '0;
      for (int i = 0; i < 3; i++) qt_src[0].rem[i] = {4'b0, rt_ff[SQRT_STAGES].nm[i][29:1]};
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_quot
      if (k > 0) begin : g_src
         assign qt_src[k] = qt_ff[k];
      end
      always_ff @(posedge clock) begin
         logic [32:0] rin;
         logic        ge;
         qt_ff[k+1].len <= qt_src[k].len;
         qt_ff[k+1].nm  <= qt_src[k].nm;
         for (int i = 0; i < 3; i++) begin
            rin = {qt_src[k].rem[i][31:0], (k == 0) ? qt_src[k].nm[i][0] : 1'b0};
            ge  = rin >= {1'b0, qt_src[k].len};
            qt_ff[k+1].rem[i] <= ge ? rin - {1'b0, qt_src[k].len} : rin;
            qt_ff[k+1].q[i]   <= {qt_src[k].q[i][29:0], ge};
         end
      end
   end

   // angle folding, radian conversion and CORDIC rotation
   mod_type            md_ff [0:QB];
   logic signed [AW-1:0] f1_ff, f2_ff;
   logic                 fl2_ff, fl3_ff, fl4_ff, ng3_ff, ng4_ff;
   logic [AW-1:0]        am3_ff;
   logic [63:0]          prod4_ff;
   cordic_type           cd_ff [0:NIT];

   always_ff @(posedge clock) begin
      logic signed [AW-1:0] d;
      d = AW'(req_angle_deg);
      md_ff[0].neg <= d[AW-1];
      md_ff[0].rem <= d[AW-1] ? -d : d;
   end

   for (genvar k = 1; k <= QB; k++) begin : g_mod
      localparam logic [AW-1:0] STEP = FULL << (QB - k);
      always_ff @(posedge clock) begin
         md_ff[k].neg <= md_ff[k-1].neg;
         md_ff[k].rem <= (md_ff[k-1].rem >= STEP) ? md_ff[k-1].rem - STEP : md_ff[k-1].rem;
      end
   end

   always_ff @(posedge clock) begin
      logic signed [AW-1:0] rm;
      rm = md_ff[QB].rem;
      if (md_ff[QB].neg && rm != '0) begin
         f1_ff <= (rm <= HALF) ? -rm : FULL - rm;
      end else begin
         f1_ff <= (rm >= HALF) ? rm - FULL : rm;
      end
      if (f1_ff > QUARTER) begin
         f2_ff  <= HALF - f1_ff;
         fl2_ff <= 1'b1;
      end else if (f1_ff < -QUARTER) begin
         f2_ff  <= -HALF - f1_ff;
         fl2_ff <= 1'b1;
      end else begin
         f2_ff  <= f1_ff;
         fl2_ff <= 1'b0;
      end
      am3_ff   <= f2_ff[AW-1] ? -f2_ff : f2_ff;
      ng3_ff   <= f2_ff[AW-1];
      fl3_ff   <= fl2_ff;
      prod4_ff <= 64'(am3_ff) * 64'(DEG_TO_RAD);
      ng4_ff   <= ng3_ff;
      fl4_ff   <= fl3_ff;
   end

   always_ff @(posedge clock) begin
      logic [63:0]          rr;
      logic signed [AW-1:0] zm;
      rr = (prod4_ff + RND) >> (FRAC_BITS + 2);
      zm = rr[AW-1:0];
      cd_ff[0].z    <= ng4_ff ? -zm : zm;
      cd_ff[0].x    <= CORDIC_GAIN;
      cd_ff[0].y    <= '0;
      cd_ff[0].flip <= fl4_ff;
   end

   for (genvar k = 0; k < NIT; k++) begin : g_cordic
      localparam logic signed [AW-1:0] ATAN = AW'(atan_q30(5'(k)));
      always_ff @(posedge clock) begin
         cd_ff[k+1].flip <= cd_ff[k].flip;
         if (!cd_ff[k].z[AW-1]) begin
            cd_ff[k+1].x <= cd_ff[k].x - (cd_ff[k].y >>> k);
            cd_ff[k+1].y <= cd_ff[k].y + (cd_ff[k].x >>> k);
            cd_ff[k+1].z <= cd_ff[k].z - ATAN;
         end else begin
            cd_ff[k+1].x <= cd_ff[k].x + (cd_ff[k].y >>> k);
            cd_ff[k+1].y <= cd_ff[k].y - (cd_ff[k].x >>> k);
            cd_ff[k+1].z <= cd_ff[k].z + ATAN;
         end
      end
   end

   logic signed [AW-1:0] cos_ff [1:DLY];
   logic signed [AW-1:0] sin_ff [1:DLY];

   always_ff @(posedge clock) begin
      cos_ff[1] <= cd_ff[NIT].flip ? -cd_ff[NIT].x : cd_ff[NIT].x;
      sin_ff[1] <= cd_ff[NIT].y;
      for (int k = 2; k <= DLY; k++) begin
         cos_ff[k] <= cos_ff[k-1];
         sin_ff[k] <= sin_ff[k-1];
      end
   end

   // Rodrigues combination
   logic [2:0][31:0]          u_ff, u1_ff, u2_ff;
   logic [2:0][2:0][WP-1:0]   pv_ff;
   logic [2:0][WP-1:0]        vc1_ff, vc2_ff, vc3_ff, vc4_ff;
   logic [2:0][WP-1:0]        cr_ff, crs_ff, crs4_ff, du_ff, t_ff;
   logic signed [WP-1:0]      d_ff;
   logic signed [AW-1:0]      c1_ff, s1_ff, s2_ff, omc_ff, omc3_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         u_ff[i] <= car_ff[S_QUOT].neg[i] ? -{1'b0, qt_ff[DIV_STAGES].q[i]}
                                          : {1'b0, qt_ff[DIV_STAGES].q[i]};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            pv_ff[i][j] <= mulq(WP'($signed(car_ff[S_UNIT].v[i])), AW'($signed(u_ff[j])));
         end
         vc1_ff[i] <= mulq(WP'($signed(car_ff[S_UNIT].v[i])), cos_ff[DLY]);
      end
      u1_ff <= u_ff;
      c1_ff <= cos_ff[DLY];
      s1_ff <= sin_ff[DLY];

      d_ff     <= $signed(pv_ff[0][0]) + $signed(pv_ff[1][1]) + $signed(pv_ff[2][2]);
      cr_ff[0] <= $signed(pv_ff[2][1]) - $signed(pv_ff[1][2]);
      cr_ff[1] <= $signed(pv_ff[0][2]) - $signed(pv_ff[2][0]);
      cr_ff[2] <= $signed(pv_ff[1][0]) - $signed(pv_ff[0][1]);
      omc_ff   <= Q30_ONE - c1_ff;
      vc2_ff   <= vc1_ff;
      u2_ff    <= u1_ff;
      s2_ff    <= s1_ff;

      for (int i = 0; i < 3; i++) begin
         crs_ff[i] <= mulq(cr_ff[i], s2_ff);
         du_ff[i]  <= mulq(d_ff, AW'($signed(u2_ff[i])));
      end
      vc3_ff  <= vc2_ff;
      omc3_ff <= omc_ff;

      for (int i = 0; i < 3; i++) t_ff[i] <= mulq(du_ff[i], omc3_ff);
      vc4_ff  <= vc3_ff;
      crs4_ff <= crs_ff;
   end

   always_ff @(posedge clock) begin
      logic signed [WP-1:0] r;
      logic [2:0][CW-1:0]   o;
      logic [2:0]           clip;
      for (int i = 0; i < 3; i++) begin
         r = $signed(vc4_ff[i]) + $signed(crs4_ff[i]) + $signed(t_ff[i]);
         clip[i] = 1'b0;
         if (r > SAT_HI) begin
            r = SAT_HI;
            clip[i] = 1'b1;
         end else if (r < SAT_LO) begin
            r = SAT_LO;
            clip[i] = 1'b1;
         end
         o[i] = r[CW-1:0];
      end
      if (car_ff[S_M4].zero) begin
         rsp_rot_x     <= car_ff[S_M4].v[0];
         rsp_rot_y     <= car_ff[S_M4].v[1];
         rsp_rot_z     <= car_ff[S_M4].v[2];
         rsp_saturated <= 1'b0;
      end else begin
         rsp_rot_x     <= o[0];
         rsp_rot_y     <= o[1];
         rsp_rot_z     <= o[2];
         rsp_saturated <= |clip;
      end
      rsp_axis_zero <= car_ff[S_M4].zero;
   end

   assign rsp_strobe = vld_ff[LATENCY];

endmodule
`default_nettype wire

[rtl/aavr_checker.sv]
// Port-level checker for the axis-angle vector rotator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module aavr_checker import aavr_pkg::*; #(
   parameter int COMP_WIDTH = 32
) (
   input wire                           clock,
   input wire                           reset,
   input wire                           start,
   input wire                           busy,
   input wire signed [COMP_WIDTH-1:0]   req_vec_x,
   input wire signed [COMP_WIDTH-1:0]   req_vec_y,
   input wire signed [COMP_WIDTH-1:0]   req_vec_z,
   input wire                           rsp_strobe,
   input wire signed [COMP_WIDTH-1:0]   rsp_rot_x,
   input wire signed [COMP_WIDTH-1:0]   rsp_rot_y,
   input wire signed [COMP_WIDTH-1:0]   rsp_rot_z,
   input wire                           rsp_axis_zero,
   input wire                           rsp_saturated
);

   `AAVR_NEVER(a_never_busy, clock, reset, busy)
   `AAVR_ASSERT(a_beat_out, clock, reset, ((start && !busy) |-> ##LATENCY rsp_strobe))
   `AAVR_ASSERT(a_beat_in, clock, reset, (rsp_strobe |-> $past(start, LATENCY)))
   `AAVR_NEVER(a_zero_clip, clock, reset, rsp_strobe && rsp_axis_zero && rsp_saturated)
   `AAVR_ASSERT(a_zero_pass, clock, reset, ((rsp_strobe && rsp_axis_zero) |->
      (rsp_rot_x == $past(req_vec_x, LATENCY) && rsp_rot_y == $past(req_vec_y, LATENCY)
       && rsp_rot_z == $past(req_vec_z, LATENCY))))

endmodule

bind axis_angle_vector_rotate aavr_checker #(.COMP_WIDTH(COMP_WIDTH)) u_aavr_checker (.*);
`default_nettype wire
